// ===== src/lsrr_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrr_pkg
// Shared types and constants for the lagged-sum random range generator.
// ----------------------------------------------------------------------------
package lsrr_pkg;

    // word widths
    localparam int LAG_W    = 15;
    localparam int DVS_W    = LAG_W + 1;
    localparam int NUM_LAGS = 4;

    // restoring divider: one quotient bit per step
    localparam int DIV_STEPS = LAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // full-scale numerator for the divisor computation
    localparam logic [LAG_W-1:0] SCALE_NUM = {LAG_W{1'b1}};

    // lag word reset values, newest first
    localparam logic [LAG_W-1:0] LAG_INIT_0 = LAG_W'(1018);
    localparam logic [LAG_W-1:0] LAG_INIT_1 = LAG_W'(4521);
    localparam logic [LAG_W-1:0] LAG_INIT_2 = LAG_W'(202);
    localparam logic [LAG_W-1:0] LAG_INIT_3 = LAG_W'(419);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_DONE
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [LAG_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    // response from the shared divider
    typedef struct packed {
        logic             done;
        logic [LAG_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== src/lsrr_div.sv =====
// ----------------------------------------------------------------------------
// lsrr_div
// Restoring divider, one quotient bit per cycle. A 15-bit dividend over a
// nonzero 16-bit divisor; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module lsrr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsrr_pkg::t_div_req i_req,
    output lsrr_pkg::t_div_rsp o_rsp
);

    logic [lsrr_pkg::LAG_W-1:0] r_rem, n_rem;
    logic [lsrr_pkg::LAG_W-1:0] r_quo, n_quo;
    logic [lsrr_pkg::DVS_W-1:0] r_dvs, n_dvs;
    logic [lsrr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;

    logic [lsrr_pkg::DVS_W-1:0] shifted;
    logic [lsrr_pkg::DVS_W:0]   diff;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {r_rem, r_quo[lsrr_pkg::LAG_W-1]};
    assign diff    = {1'b0, shifted} - {1'b0, r_dvs};

    // next-value logic
    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_cnt  = lsrr_pkg::CNT_W'(lsrr_pkg::DIV_STEPS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[lsrr_pkg::DVS_W]) begin
                // remainder stays below the divisor, so it fits the low bits
                n_rem = diff[lsrr_pkg::LAG_W-1:0];
                n_quo = {r_quo[lsrr_pkg::LAG_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[lsrr_pkg::LAG_W-1:0];
                n_quo = {r_quo[lsrr_pkg::LAG_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == lsrr_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== src/lagged_sum_random_range_top.sv =====
// ----------------------------------------------------------------------------
// lagged_sum_random_range_top
// Additive lagged-sum random generator scaled to a requested inclusive range.
// ----------------------------------------------------------------------------
// Each request carries an inclusive upper limit. On the transfer the four
// 15-bit lag words are summed modulo 2^15, the words shift by one and the sum
// becomes the newest word. The sum is then scaled by two serial divisions on
// one shared restoring divider: divisor = 32767 / (limit + 1), forced to one
// when zero, then value = sum / divisor, clamped to the limit. o_in_stall stays
// high from the transfer until the result is moved into the output register.
// The result sits in that output register, so the next request is taken
// while a finished result still waits downstream.
// Lag words reset to 1018, 4521, 202, 419, newest first.
// ----------------------------------------------------------------------------
module lagged_sum_random_range_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [lsrr_pkg::LAG_W-1:0] i_range_limit,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [lsrr_pkg::LAG_W-1:0] o_random_value
);

    lsrr_pkg::t_state r_state, n_state;

    logic [lsrr_pkg::LAG_W-1:0] r_lag [lsrr_pkg::NUM_LAGS];
    logic [lsrr_pkg::LAG_W-1:0] r_limit;
    logic [lsrr_pkg::LAG_W-1:0] r_sum;
    logic [lsrr_pkg::LAG_W-1:0] r_val;
    logic [lsrr_pkg::LAG_W-1:0] r_out;
    logic                       r_out_valid;

    logic                       in_xfer;
    logic                       out_free;
    logic [lsrr_pkg::LAG_W+1:0] sum_full;
    logic [lsrr_pkg::LAG_W-1:0] scale_dvs;
    logic [lsrr_pkg::LAG_W-1:0] clamped;

    lsrr_pkg::t_div_req div_req;
    lsrr_pkg::t_div_rsp div_rsp;

    // shared divider
    lsrr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // sum of the lag words, modulo 2^15 by truncation
    assign sum_full = {2'b00, r_lag[0]} + {2'b00, r_lag[1]}
                    + {2'b00, r_lag[2]} + {2'b00, r_lag[3]};

    // zero divisor only for the top limit; force it to one
    assign scale_dvs = (div_rsp.quotient == '0) ? lsrr_pkg::LAG_W'(1)
                                                : div_rsp.quotient;

    // clamp the scaled value to the limit
    assign clamped = (div_rsp.quotient > r_limit) ? r_limit : div_rsp.quotient;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsrr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lsrr_pkg::S_DIV1;
            end
            lsrr_pkg::S_DIV1: begin
                if (div_rsp.done) n_state = lsrr_pkg::S_DIV2;
            end
            lsrr_pkg::S_DIV2: begin
                if (div_rsp.done) n_state = lsrr_pkg::S_DONE;
            end
            lsrr_pkg::S_DONE: begin
                if (out_free) n_state = lsrr_pkg::S_IDLE;
            end
            default: n_state = lsrr_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall       = 1'b1;
        div_req.start    = 1'b0;
        div_req.dividend = lsrr_pkg::SCALE_NUM;
        div_req.divisor  = {1'b0, i_range_limit} + lsrr_pkg::DVS_W'(1);
        case (r_state)
            lsrr_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                div_req.start = i_in_valid;
            end
            lsrr_pkg::S_DIV1: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = r_sum;
                div_req.divisor  = {1'b0, scale_dvs};
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsrr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_lag[0]    <= lsrr_pkg::LAG_INIT_0;
            r_lag[1]    <= lsrr_pkg::LAG_INIT_1;
            r_lag[2]    <= lsrr_pkg::LAG_INIT_2;
            r_lag[3]    <= lsrr_pkg::LAG_INIT_3;
        end else begin
            r_state <= n_state;
            // lag shift line advances on each input transfer
            if (in_xfer) begin
                r_lag[0] <= sum_full[lsrr_pkg::LAG_W-1:0];
                for (int i = 1; i < lsrr_pkg::NUM_LAGS; i++) begin
                    r_lag[i] <= r_lag[i-1];
                end
            end
            // output register valid
            if (r_state == lsrr_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_limit <= i_range_limit;
            r_sum   <= sum_full[lsrr_pkg::LAG_W-1:0];
        end
        if (r_state == lsrr_pkg::S_DIV2 && div_rsp.done) begin
            r_val <= clamped;
        end
        if (r_state == lsrr_pkg::S_DONE && out_free) begin
            r_out <= r_val;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out;

endmodule
